// File: rtl/ate_pkg.sv
// Shared types, codes and color tables of the text console engine.
package ate_pkg;

    // Widest cell address over the whole parameter range (256 x 128 cells)
    localparam int ADDR_W = 15;

    // Request kinds
    localparam logic [1:0] REQ_FEED  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic CFG_DEF_FG = 1'b0;
    localparam logic CFG_DEF_BG = 1'b1;

    // Character codes
    localparam logic [7:0] CH_ESC     = 8'h1B;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_BS      = 8'h08;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_BLANK   = 8'h20;

    // CSI final bytes
    localparam logic [7:0] CMD_UP    = 8'h41;
    localparam logic [7:0] CMD_DOWN  = 8'h42;
    localparam logic [7:0] CMD_FWD   = 8'h43;
    localparam logic [7:0] CMD_BACK  = 8'h44;
    localparam logic [7:0] CMD_POS   = 8'h48;
    localparam logic [7:0] CMD_POSF  = 8'h66;
    localparam logic [7:0] CMD_ED    = 8'h4A;
    localparam logic [7:0] CMD_EL    = 8'h4B;
    localparam logic [7:0] CMD_SGR   = 8'h6D;

    // Attribute after reset: white on black
    localparam logic [7:0] RESET_ATTR = 8'h0F;

    // Parameter limits
    localparam logic [15:0] PARAM_MAX = 16'hFFFF;

    // SGR codes and ranges
    localparam logic [15:0] SGR_RESET   = 16'd0;
    localparam logic [15:0] SGR_BOLD    = 16'd1;
    localparam logic [15:0] SGR_FG_LO   = 16'd30;
    localparam logic [15:0] SGR_FG_HI   = 16'd37;
    localparam logic [15:0] SGR_FG_DEF  = 16'd39;
    localparam logic [15:0] SGR_BG_LO   = 16'd40;
    localparam logic [15:0] SGR_BG_HI   = 16'd47;
    localparam logic [15:0] SGR_BG_DEF  = 16'd49;
    localparam logic [15:0] SGR_BFG_LO  = 16'd90;
    localparam logic [15:0] SGR_BFG_HI  = 16'd97;
    localparam logic [15:0] SGR_BBG_LO  = 16'd100;
    localparam logic [15:0] SGR_BBG_HI  = 16'd107;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESC    = 2'd1,
        MODE_CSI    = 2'd2
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_SCRL0,
        ST_SCROLL,
        ST_FILL,
        ST_CSI,
        ST_SGR,
        ST_DONE
    } state_t;

    // One write port and one read port of the screen store
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [15:0]       wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    // Finished result handed to the output register
    typedef struct packed {
        logic              done;
        logic [15:0]       cell_data;
        logic [ADDR_W-1:0] cursor;
        logic [7:0]        color;
        logic              esc;
    } eng_res_t;

    // ANSI color order to console color index
    function automatic logic [3:0] base_color(input logic [2:0] idx);
        logic [3:0] c;
        unique case (idx)
            3'd0: c = 4'd0;
            3'd1: c = 4'd4;
            3'd2: c = 4'd2;
            3'd3: c = 4'd6;
            3'd4: c = 4'd1;
            3'd5: c = 4'd5;
            3'd6: c = 4'd3;
            default: c = 4'd7;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/ate_req_if.sv
// Request channel: valid, ready and one request item.
interface ate_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  char_byte;
    logic [10:0] cell_address;

    modport source (output valid, output req_type, output char_byte, output cell_address,
                    input ready);
    modport sink   (input valid, input req_type, input char_byte, input cell_address,
                    output ready);
endinterface

// File: rtl/ate_rsp_if.sv
// Response channel: valid, ready and one result item.
interface ate_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] cell_data;
    logic [10:0] cursor_position;
    logic [7:0]  text_color;
    logic        in_escape;

    modport source (output valid, output cell_data, output cursor_position,
                    output text_color, output in_escape, input ready);
    modport sink   (input valid, input cell_data, input cursor_position,
                    input text_color, input in_escape, output ready);
endinterface

// File: rtl/ate_screen_ram.sv
// Screen cell store: one write port, one registered read port.
module ate_screen_ram #(
    parameter int DEPTH = 2000
) (
    input  logic                clk,
    input  ate_pkg::mem_req_t   mem_req,
    output logic [15:0]         rd_q
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [15:0] cells [DEPTH];

    // Write cell
    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            cells[mem_req.waddr[AW-1:0]] <= mem_req.wdata;
        end
    end

    // Read cell, data ready in the next cycle
    always_ff @(posedge clk)
    begin
        if (mem_req.re)
        begin
            rd_q <= cells[mem_req.raddr[AW-1:0]];
        end
    end
endmodule

// File: rtl/ate_engine.sv
// Escape parser, cursor control and screen store sequencer.
module ate_engine #(
    parameter int COLUMNS    = 80,
    parameter int ROWS       = 25,
    parameter int MAX_PARAMS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic [1:0]          req_type,
    input  logic [7:0]          char_byte,
    input  logic [10:0]         cell_address,
    input  logic                out_free,
    input  logic [3:0]          def_fg,
    input  logic [3:0]          def_bg,
    input  logic [15:0]         rd_q,
    output ate_pkg::mem_req_t   mem_req,
    output ate_pkg::eng_res_t   res
);
    localparam int TOTAL = COLUMNS * ROWS;
    localparam int AW    = $clog2(TOTAL);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int PIW   = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int PCW   = $clog2(MAX_PARAMS + 1);

    localparam logic [AW-1:0]  LAST_CELL   = AW'(TOTAL - 1);
    localparam logic [AW-1:0]  LAST_ROW0   = AW'(TOTAL - COLUMNS);
    localparam logic [AW-1:0]  LAST_MOVE   = AW'(TOTAL - COLUMNS - 1);
    localparam logic [AW-1:0]  COLS_A      = AW'(COLUMNS);
    localparam logic [RW-1:0]  ROW_LAST    = RW'(ROWS - 1);
    localparam logic [CW-1:0]  COL_LAST    = CW'(COLUMNS - 1);
    localparam logic [PCW-1:0] PCOUNT_MAX  = PCW'(MAX_PARAMS);

    ate_pkg::state_t state_reg, state_next;
    ate_pkg::mode_t  mode_reg, mode_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [7:0]      attr_reg, attr_next;
    logic [15:0]     params_reg [MAX_PARAMS];
    logic [15:0]     params_next [MAX_PARAMS];
    logic [PCW-1:0]  pcount_reg, pcount_next;
    logic [15:0]     acc_reg, acc_next;
    logic            started_reg, started_next;
    logic [7:0]      cmd_reg, cmd_next;
    logic [AW-1:0]   ptr_reg, ptr_next;
    logic [AW-1:0]   last_reg, last_next;
    logic [PIW-1:0]  sidx_reg, sidx_next;
    logic            init_reg, init_next;
    logic [15:0]     data_reg, data_next;

    logic [AW-1:0]   row_base;
    logic [AW-1:0]   cur;
    logic [15:0]     blank;
    logic [15:0]     p0;
    logic [15:0]     p1;
    logic [15:0]     p0m1;
    logic [15:0]     p1m1;
    logic [16:0]     row_sum;
    logic [16:0]     col_sum;
    logic [19:0]     acc_wide;
    logic [15:0]     sp;
    logic [3:0]      fg;
    logic [3:0]      bg;

    // Cursor index from row and column
    assign row_base = AW'(row_reg) * COLS_A;
    assign cur      = row_base + AW'(col_reg);
    assign blank    = {attr_reg, ate_pkg::CH_BLANK};

    // Leading parameters with their defaults of one
    always_comb
    begin
        p0 = 16'd1;
        p1 = 16'd1;
        if ((pcount_reg > PCW'(0)) && (params_reg[0] != 16'd0))
        begin
            p0 = params_reg[0];
        end
        if ((MAX_PARAMS > 1) && (pcount_reg > PCW'(1)) &&
            (params_reg[PIW'(MAX_PARAMS > 1)] != 16'd0))
        begin
            p1 = params_reg[PIW'(MAX_PARAMS > 1)];
        end
    end

    assign p0m1     = p0 - 16'd1;
    assign p1m1     = p1 - 16'd1;
    assign row_sum  = 17'(row_reg) + 17'(p0);
    assign col_sum  = 17'(col_reg) + 17'(p0);
    assign acc_wide = 20'(acc_reg) * 20'd10 + 20'(char_byte - ate_pkg::CH_ZERO);
    assign sp       = params_reg[sidx_reg];

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ate_pkg::ST_FILL;
            mode_reg    <= ate_pkg::MODE_NORMAL;
            row_reg     <= '0;
            col_reg     <= '0;
            attr_reg    <= ate_pkg::RESET_ATTR;
            pcount_reg  <= '0;
            acc_reg     <= '0;
            started_reg <= 1'b0;
            ptr_reg     <= '0;
            last_reg    <= LAST_CELL;
            sidx_reg    <= '0;
            init_reg    <= 1'b1;
            for (int i = 0; i < MAX_PARAMS; i++)
            begin
                params_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            attr_reg    <= attr_next;
            pcount_reg  <= pcount_next;
            acc_reg     <= acc_next;
            started_reg <= started_next;
            ptr_reg     <= ptr_next;
            last_reg    <= last_next;
            sidx_reg    <= sidx_next;
            init_reg    <= init_next;
            for (int i = 0; i < MAX_PARAMS; i++)
            begin
                params_reg[i] <= params_next[i];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        data_reg <= data_next;
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        attr_next    = attr_reg;
        params_next  = params_reg;
        pcount_next  = pcount_reg;
        acc_next     = acc_reg;
        started_next = started_reg;
        cmd_next     = cmd_reg;
        ptr_next     = ptr_reg;
        last_next    = last_reg;
        sidx_next    = sidx_reg;
        init_next    = init_reg;
        data_next    = data_reg;
        mem_req      = '0;
        req_ready    = (state_reg == ate_pkg::ST_IDLE);
        res.done      = 1'b0;
        res.cell_data = data_reg;
        res.cursor    = ate_pkg::ADDR_W'(cur);
        res.color     = attr_reg;
        res.esc       = (mode_reg != ate_pkg::MODE_NORMAL);
        fg = attr_reg[3:0];
        bg = attr_reg[7:4];

        unique case (state_reg)
            ate_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    data_next  = 16'd0;
                    state_next = ate_pkg::ST_DONE;
                    case (req_type)
                        ate_pkg::REQ_FEED:
                        begin
                            unique case (mode_reg)
                                ate_pkg::MODE_NORMAL:
                                begin
                                    if (char_byte == ate_pkg::CH_ESC)
                                    begin
                                        mode_next = ate_pkg::MODE_ESC;
                                    end
                                    else if (char_byte == ate_pkg::CH_LF)
                                    begin
                                        col_next = '0;
                                        if (row_reg == ROW_LAST)
                                        begin
                                            state_next = ate_pkg::ST_SCRL0;
                                        end
                                        else
                                        begin
                                            row_next = row_reg + RW'(1);
                                        end
                                    end
                                    else if (char_byte == ate_pkg::CH_BS)
                                    begin
                                        if (cur != '0)
                                        begin
                                            mem_req.we    = 1'b1;
                                            mem_req.waddr = ate_pkg::ADDR_W'(cur - AW'(1));
                                            mem_req.wdata = blank;
                                            if (col_reg != '0)
                                            begin
                                                col_next = col_reg - CW'(1);
                                            end
                                            else
                                            begin
                                                col_next = COL_LAST;
                                                row_next = row_reg - RW'(1);
                                            end
                                        end
                                    end
                                    else if (char_byte == ate_pkg::CH_CR)
                                    begin
                                        col_next = '0;
                                    end
                                    else
                                    begin
                                        mem_req.we    = 1'b1;
                                        mem_req.waddr = ate_pkg::ADDR_W'(cur);
                                        mem_req.wdata = {attr_reg, char_byte};
                                        if (col_reg == COL_LAST)
                                        begin
                                            col_next = '0;
                                            if (row_reg == ROW_LAST)
                                            begin
                                                state_next = ate_pkg::ST_SCRL0;
                                            end
                                            else
                                            begin
                                                row_next = row_reg + RW'(1);
                                            end
                                        end
                                        else
                                        begin
                                            col_next = col_reg + CW'(1);
                                        end
                                    end
                                end
                                ate_pkg::MODE_ESC:
                                begin
                                    if (char_byte == ate_pkg::CH_LBRACK)
                                    begin
                                        mode_next    = ate_pkg::MODE_CSI;
                                        pcount_next  = '0;
                                        acc_next     = '0;
                                        started_next = 1'b0;
                                        for (int i = 0; i < MAX_PARAMS; i++)
                                        begin
                                            params_next[i] = '0;
                                        end
                                    end
                                    else
                                    begin
                                        mode_next = ate_pkg::MODE_NORMAL;
                                    end
                                end
                                default:
                                begin
                                    if ((char_byte >= ate_pkg::CH_ZERO) &&
                                        (char_byte <= ate_pkg::CH_NINE))
                                    begin
                                        acc_next = (acc_wide > 20'(ate_pkg::PARAM_MAX)) ?
                                                   ate_pkg::PARAM_MAX : acc_wide[15:0];
                                        started_next = 1'b1;
                                    end
                                    else
                                    begin
                                        // Close the open parameter on ';' or a final byte
                                        if ((char_byte == ate_pkg::CH_SEMI) || started_reg ||
                                            (pcount_reg != '0))
                                        begin
                                            if (pcount_reg < PCOUNT_MAX)
                                            begin
                                                params_next[pcount_reg[PIW-1:0]] = acc_reg;
                                                pcount_next = pcount_reg + PCW'(1);
                                            end
                                            acc_next     = '0;
                                            started_next = 1'b0;
                                        end
                                        if (char_byte != ate_pkg::CH_SEMI)
                                        begin
                                            cmd_next   = char_byte;
                                            mode_next  = ate_pkg::MODE_NORMAL;
                                            state_next = ate_pkg::ST_CSI;
                                        end
                                    end
                                end
                            endcase
                        end
                        ate_pkg::REQ_READ:
                        begin
                            if (32'(cell_address) < TOTAL)
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = ate_pkg::ADDR_W'(cell_address);
                                state_next    = ate_pkg::ST_RD;
                            end
                            else
                            begin
                                data_next = {8'h00, ate_pkg::CH_BLANK};
                            end
                        end
                        ate_pkg::REQ_CLEAR:
                        begin
                            row_next   = '0;
                            col_next   = '0;
                            ptr_next   = '0;
                            last_next  = LAST_CELL;
                            state_next = ate_pkg::ST_FILL;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ate_pkg::ST_RD:
            begin
                data_next  = rd_q;
                state_next = ate_pkg::ST_DONE;
            end

            // Prime the read one row ahead
            ate_pkg::ST_SCRL0:
            begin
                mem_req.re    = 1'b1;
                mem_req.raddr = ate_pkg::ADDR_W'(COLS_A);
                ptr_next      = '0;
                state_next    = ate_pkg::ST_SCROLL;
            end

            // Move each cell up one row, then blank the bottom row
            ate_pkg::ST_SCROLL:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = ate_pkg::ADDR_W'(ptr_reg);
                mem_req.wdata = rd_q;
                if (ptr_reg == LAST_MOVE)
                begin
                    ptr_next   = LAST_ROW0;
                    last_next  = LAST_CELL;
                    state_next = ate_pkg::ST_FILL;
                end
                else
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = ate_pkg::ADDR_W'(ptr_reg + COLS_A + AW'(1));
                    ptr_next      = ptr_reg + AW'(1);
                end
            end

            ate_pkg::ST_FILL:
            begin
                req_ready     = 1'b0;
                mem_req.we    = 1'b1;
                mem_req.waddr = ate_pkg::ADDR_W'(ptr_reg);
                mem_req.wdata = blank;
                if (ptr_reg == last_reg)
                begin
                    init_next  = 1'b0;
                    state_next = init_reg ? ate_pkg::ST_IDLE : ate_pkg::ST_DONE;
                end
                else
                begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end

            ate_pkg::ST_CSI:
            begin
                state_next = ate_pkg::ST_DONE;
                case (cmd_reg)
                    ate_pkg::CMD_UP:
                    begin
                        row_next = (p0 > 16'(row_reg)) ? '0 : row_reg - RW'(p0);
                    end
                    ate_pkg::CMD_DOWN:
                    begin
                        row_next = (row_sum >= 17'(ROWS)) ? ROW_LAST : RW'(row_sum);
                    end
                    ate_pkg::CMD_FWD:
                    begin
                        col_next = (col_sum >= 17'(COLUMNS)) ? COL_LAST : CW'(col_sum);
                    end
                    ate_pkg::CMD_BACK:
                    begin
                        col_next = (p0 > 16'(col_reg)) ? '0 : col_reg - CW'(p0);
                    end
                    ate_pkg::CMD_POS, ate_pkg::CMD_POSF:
                    begin
                        row_next = (p0m1 >= 16'(ROWS)) ? ROW_LAST : RW'(p0m1);
                        col_next = (p1m1 >= 16'(COLUMNS)) ? COL_LAST : CW'(p1m1);
                    end
                    ate_pkg::CMD_ED:
                    begin
                        // p0 of one stands for an absent or zero parameter here
                        if ((p0 == 16'd1) && !((pcount_reg > PCW'(0)) &&
                                               (params_reg[0] == 16'd1)))
                        begin
                            ptr_next   = cur;
                            last_next  = LAST_CELL;
                            state_next = ate_pkg::ST_FILL;
                        end
                        else if (p0 == 16'd1)
                        begin
                            ptr_next   = '0;
                            last_next  = cur;
                            state_next = ate_pkg::ST_FILL;
                        end
                        else if (p0 == 16'd2)
                        begin
                            ptr_next   = '0;
                            last_next  = LAST_CELL;
                            row_next   = '0;
                            col_next   = '0;
                            state_next = ate_pkg::ST_FILL;
                        end
                    end
                    ate_pkg::CMD_EL:
                    begin
                        if ((p0 == 16'd1) && !((pcount_reg > PCW'(0)) &&
                                               (params_reg[0] == 16'd1)))
                        begin
                            ptr_next   = cur;
                            last_next  = row_base + AW'(COL_LAST);
                            state_next = ate_pkg::ST_FILL;
                        end
                        else if (p0 == 16'd1)
                        begin
                            ptr_next   = row_base;
                            last_next  = cur;
                            state_next = ate_pkg::ST_FILL;
                        end
                        else if (p0 == 16'd2)
                        begin
                            ptr_next   = row_base;
                            last_next  = row_base + AW'(COL_LAST);
                            state_next = ate_pkg::ST_FILL;
                        end
                    end
                    ate_pkg::CMD_SGR:
                    begin
                        if (pcount_reg == '0)
                        begin
                            attr_next = {def_bg, def_fg};
                        end
                        else
                        begin
                            sidx_next  = '0;
                            state_next = ate_pkg::ST_SGR;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            // Apply one SGR parameter a cycle
            ate_pkg::ST_SGR:
            begin
                if (sp == ate_pkg::SGR_RESET)
                begin
                    fg = def_fg;
                    bg = def_bg;
                end
                else if (sp == ate_pkg::SGR_BOLD)
                begin
                    fg = fg | 4'd8;
                end
                else if ((sp >= ate_pkg::SGR_FG_LO) && (sp <= ate_pkg::SGR_FG_HI))
                begin
                    fg = ate_pkg::base_color(sp[2:0] - ate_pkg::SGR_FG_LO[2:0]);
                end
                else if (sp == ate_pkg::SGR_FG_DEF)
                begin
                    fg = def_fg;
                end
                else if ((sp >= ate_pkg::SGR_BG_LO) && (sp <= ate_pkg::SGR_BG_HI))
                begin
                    bg = ate_pkg::base_color(sp[2:0] - ate_pkg::SGR_BG_LO[2:0]);
                end
                else if (sp == ate_pkg::SGR_BG_DEF)
                begin
                    bg = def_bg;
                end
                else if ((sp >= ate_pkg::SGR_BFG_LO) && (sp <= ate_pkg::SGR_BFG_HI))
                begin
                    fg = ate_pkg::base_color(sp[2:0] - ate_pkg::SGR_BFG_LO[2:0]) | 4'd8;
                end
                else if ((sp >= ate_pkg::SGR_BBG_LO) && (sp <= ate_pkg::SGR_BBG_HI))
                begin
                    bg = ate_pkg::base_color(sp[2:0] - ate_pkg::SGR_BBG_LO[2:0]) | 4'd8;
                end
                attr_next = {bg, fg};
                if ((PCW'(sidx_reg) + PCW'(1)) >= pcount_reg)
                begin
                    state_next = ate_pkg::ST_DONE;
                end
                else
                begin
                    sidx_next = sidx_reg + PIW'(1);
                end
            end

            // Hand the result over once the output register has room
            ate_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    res.done   = 1'b1;
                    state_next = ate_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ate_pkg::ST_IDLE;
            end
        endcase
    end
endmodule

// File: rtl/ansi_text_console_engine.sv
// Flow: plain characters and controls go to the done state, reads pass the read state, CSI
// the command state and SGR one step per parameter; scroll moves cells, erases fill them.
// Throughput: one item at a time; the single write port of the screen store sets scroll
// and erase time. A finished result waits in the output register while the next is taken.
// Reset: asynchronous, active low; a clearing pass over every cell then blanks
// the screen store before the first item is accepted (configuration writes still taken).
module ansi_text_console_engine #(
    parameter int COLUMNS    = 80,
    parameter int ROWS       = 25,
    parameter int MAX_PARAMS = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    ate_req_if.sink      req,
    ate_rsp_if.source    rsp,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [3:0]   cfg_data
);
    logic [3:0]        def_fg_reg;
    logic [3:0]        def_bg_reg;
    logic              out_valid_reg;
    logic [15:0]       out_data_reg;
    logic [10:0]       out_cursor_reg;
    logic [7:0]        out_color_reg;
    logic              out_esc_reg;
    logic              out_free;
    logic [15:0]       rd_q;
    ate_pkg::mem_req_t mem_req;
    ate_pkg::eng_res_t res;

    // Hold the default colors
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            def_fg_reg <= 4'd15;
            def_bg_reg <= 4'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ate_pkg::CFG_DEF_FG: def_fg_reg <= cfg_data;
                default:             def_bg_reg <= cfg_data;
            endcase
        end
    end

    assign out_free = !out_valid_reg || rsp.ready;

    // Output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.done)
        begin
            out_data_reg   <= res.cell_data;
            out_cursor_reg <= res.cursor[10:0];
            out_color_reg  <= res.color;
            out_esc_reg    <= res.esc;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.cell_data       = out_data_reg;
    assign rsp.cursor_position = out_cursor_reg;
    assign rsp.text_color      = out_color_reg;
    assign rsp.in_escape       = out_esc_reg;

    ate_engine #(
        .COLUMNS    (COLUMNS),
        .ROWS       (ROWS),
        .MAX_PARAMS (MAX_PARAMS)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req.valid),
        .req_ready    (req.ready),
        .req_type     (req.req_type),
        .char_byte    (req.char_byte),
        .cell_address (req.cell_address),
        .out_free     (out_free),
        .def_fg       (def_fg_reg),
        .def_bg       (def_bg_reg),
        .rd_q         (rd_q),
        .mem_req      (mem_req),
        .res          (res)
    );

    ate_screen_ram #(
        .DEPTH (COLUMNS * ROWS)
    ) u_ram (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_q    (rd_q)
    );
endmodule

// File: rtl/ate_checker.sv
// Port-level checks of the text console engine and their bind.
module ate_checker #(
    parameter int TOTAL_CELLS = 2000
) (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [10:0] rsp_cursor
);
    // Hold a stalled result beat
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result beat dropped while stalled");

    // Keep the cursor on the screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (32'(rsp_cursor) < TOTAL_CELLS))
        else $error("cursor beyond the screen");

    // Take one item at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("new item taken while one is in work");
endmodule

bind ansi_text_console_engine ate_checker #(
    .TOTAL_CELLS (COLUMNS * ROWS)
) u_ate_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_cursor (rsp.cursor_position)
);
